@@ rtl/etp_pkg.sv @@
// ----------------------------------------------------------------------------
// etp_pkg
// Shared types, codes and constants of the encoder target positioner.
// ----------------------------------------------------------------------------
package etp_pkg;

  // Pulse counter width (8..32); position shows the low 16 bits.
  localparam int COUNT_WIDTH = 16;
  localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [COUNT_WIDTH-1:0] IDLE_GOAL = COUNT_WIDTH'(-26715);
  localparam logic [7:0]             FULL_DUTY = 8'd255;

  // Absolute move scaling: round(mm * stroke_pulses / 150), ties away from zero.
  // Done as floor(((|p| + 75) >> 1) / 75) with a reciprocal and one fixup.
  localparam int STROKE_MM   = 150;
  localparam int HALF_STROKE = STROKE_MM / 2;
  localparam int HALF_DIV    = STROKE_MM / 2;
  localparam int RECIP_SHIFT = 36;
  localparam logic [29:0] RECIP = 30'((64'd1 << RECIP_SHIFT) / HALF_DIV);
  localparam int MAG_W  = 30;             // |mm * stroke_pulses| + 75 < 2^30
  localparam int HALF_W = MAG_W - 1;
  localparam int QUO_W  = 23;             // quotient < 2^23
  localparam int PROD_W = HALF_W + 30;

  // Register indexes of the configuration port.
  localparam logic REG_STROKE_PULSES = 1'b0;
  localparam logic REG_PULSE_LIMIT   = 1'b1;

  localparam logic [14:0] STROKE_PULSES_RST = 15'd1000;
  localparam logic signed [15:0] PULSE_LIMIT_RST = 16'sd32767;

  // Mode codes of the command transaction.
  localparam logic [2:0] MODE_PULSE = 3'd0;
  localparam logic [2:0] MODE_REL   = 3'd1;
  localparam logic [2:0] MODE_ABS   = 3'd2;
  localparam logic [2:0] MODE_HOME  = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;

  // Work queue depth.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PULSE,
    OP_REL,
    OP_ABS,
    OP_HOME,
    OP_TICK,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               pulse_reverse;
    logic signed [15:0] displacement;
    logic signed [15:0] target_mm;
    logic [7:0]         speed;
    logic               home_forward;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic               move_done;
    logic               drive_forward;
    logic [7:0]         duty;
    logic               homing_active;
  } status_t;

  // Classified work item handed from front to back.
  typedef struct packed {
    op_t                      op;
    logic                     pulse_reverse;
    logic signed [15:0]       displacement;
    logic [7:0]               speed;
    logic                     home_forward;
    logic [COUNT_WIDTH-1:0]   abs_goal;
  } work_t;

endpackage

@@ rtl/etp_front.sv @@
// ----------------------------------------------------------------------------
// etp_front
// Accepts commands, decodes the mode and scales absolute targets to pulses.
// ----------------------------------------------------------------------------
module etp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  etp_pkg::cmd_t         cmd,
  input  logic [14:0]           stroke_pulses,
  output etp_pkg::work_t        work,
  output logic                  work_push,
  input  logic                  work_full
);
  import etp_pkg::*;

  // stage 1: decode, mm * stroke_pulses
  logic               v1;
  work_t              w1;
  logic               neg1;
  logic [MAG_W-1:0]   mag1;
  // stage 2: reciprocal product
  logic               v2;
  work_t              w2;
  logic               neg2;
  logic [HALF_W-1:0]  half2;
  logic [PROD_W-1:0]  prod2;
  // stage 3: finished work item
  logic               v3;
  work_t              w3;

  logic               advance;
  op_t                op_dec;
  logic signed [31:0] prod_mm;
  logic [MAG_W-1:0]   mag_mm;
  logic [HALF_W-1:0]  half_mm;
  logic [QUO_W-1:0]   quo_est;
  logic [HALF_W-1:0]  rem_est;
  logic [QUO_W-1:0]   quo;
  logic signed [QUO_W:0] quo_s;
  work_t              w1_in;
  work_t              w3_in;

  assign advance   = !(v3 && work_full);
  assign cmd_stall = !advance;
  assign work_push = v3 && !work_full;
  assign work      = w3;

  always_comb begin
    unique case (cmd.mode)
      MODE_PULSE: op_dec = OP_PULSE;
      MODE_REL:   op_dec = OP_REL;
      MODE_ABS:   op_dec = OP_ABS;
      MODE_HOME:  op_dec = OP_HOME;
      MODE_TICK:  op_dec = OP_TICK;
      MODE_CLEAR: op_dec = OP_CLEAR;
      default:    op_dec = OP_NONE;
    endcase
  end

  assign prod_mm = $signed(cmd.target_mm) * $signed({1'b0, stroke_pulses});
  assign mag_mm  = prod_mm[31] ? MAG_W'(-prod_mm) : MAG_W'(prod_mm);

  always_comb begin
    w1_in               = '0;
    w1_in.op            = op_dec;
    w1_in.pulse_reverse = cmd.pulse_reverse;
    w1_in.displacement  = cmd.displacement;
    w1_in.speed         = cmd.speed;
    w1_in.home_forward  = cmd.home_forward;
  end

  // floor(half / 75): estimate is exact or one low
  assign half_mm = HALF_W'((mag1 + MAG_W'(HALF_STROKE)) >> 1);
  assign quo_est = prod2[PROD_W-1 -: QUO_W];
  assign rem_est = half2 - HALF_W'(quo_est) * HALF_W'(HALF_DIV);
  assign quo     = (rem_est >= HALF_W'(HALF_DIV)) ? quo_est + 1'b1 : quo_est;
  assign quo_s   = neg2 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    w3_in          = w2;
    w3_in.abs_goal = COUNT_WIDTH'(quo_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= cmd_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      w1    <= w1_in;
      neg1  <= prod_mm[31];
      mag1  <= mag_mm;
      w2    <= w1;
      neg2  <= neg1;
      half2 <= half_mm;
      prod2 <= PROD_W'(half_mm) * PROD_W'(RECIP);
      w3    <= w3_in;
    end
  end

endmodule

@@ rtl/etp_queue.sv @@
// ----------------------------------------------------------------------------
// etp_queue
// Short work queue between the front and back parts.
// ----------------------------------------------------------------------------
module etp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  etp_pkg::work_t  wr_data,
  input  logic            pop,
  output logic            ready_n,
  output etp_pkg::work_t  rd_data
);
  import etp_pkg::*;

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  // ready_n: queue empty
  assign full    = (fill == QCNT_W'(QUEUE_DEPTH));
  assign ready_n = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/etp_back.sv @@
// ----------------------------------------------------------------------------
// etp_back
// Executes work items against the positioner state; registered status out.
// ----------------------------------------------------------------------------
module etp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_empty,
  input  etp_pkg::work_t     work,
  output logic               work_pop,
  input  logic signed [15:0] pulse_limit,
  output logic               status_valid,
  input  logic               status_stall,
  output etp_pkg::status_t   status
);
  import etp_pkg::*;

  logic [COUNT_WIDTH-1:0] pulse_count, pulse_count_next;
  logic [COUNT_WIDTH-1:0] goal_count, goal_count_next;
  logic                   finished, finished_next;
  logic                   dir_forward, dir_forward_next;
  logic [7:0]             duty_level, duty_level_next;
  logic                   home_run, home_run_next;

  logic [COUNT_WIDTH-1:0]   stepped;
  logic signed [CMP_W-1:0]  stepped_ext;
  logic signed [CMP_W-1:0]  limit_ext;
  logic signed [COUNT_WIDTH:0] abs_diff;
  logic                     stop_hit;

  assign work_pop = !work_empty && (!status_valid || !status_stall);

  assign stepped     = work.pulse_reverse ? pulse_count - 1'b1 : pulse_count + 1'b1;
  assign stepped_ext = CMP_W'($signed(stepped));
  assign limit_ext   = CMP_W'(pulse_limit);
  assign stop_hit    = (stepped == goal_count) || (stepped_ext > limit_ext);
  assign abs_diff    = $signed({work.abs_goal[COUNT_WIDTH-1], work.abs_goal})
                     - $signed({pulse_count[COUNT_WIDTH-1], pulse_count});

  always_comb begin
    pulse_count_next = pulse_count;
    goal_count_next  = goal_count;
    finished_next    = finished;
    dir_forward_next = dir_forward;
    duty_level_next  = duty_level;
    home_run_next    = home_run;
    unique case (work.op)
      OP_PULSE: begin
        pulse_count_next = stepped;
        if (stop_hit) begin
          dir_forward_next = 1'b1;
          duty_level_next  = '0;
          finished_next    = 1'b1;
          goal_count_next  = IDLE_GOAL;
        end
      end
      OP_REL: begin
        goal_count_next  = pulse_count + COUNT_WIDTH'(work.displacement);
        finished_next    = 1'b0;
        dir_forward_next = !work.displacement[15] || (work.speed == '0);
        duty_level_next  = work.speed;
      end
      OP_ABS: begin
        goal_count_next  = work.abs_goal;
        finished_next    = 1'b0;
        dir_forward_next = !abs_diff[COUNT_WIDTH] || (work.speed == '0);
        duty_level_next  = work.speed;
      end
      OP_HOME: begin
        finished_next    = 1'b0;
        dir_forward_next = work.home_forward;
        duty_level_next  = FULL_DUTY;
        pulse_count_next = '1;
        home_run_next    = 1'b1;
      end
      OP_TICK: begin
        if (home_run) begin
          pulse_count_next = '0;
          if (pulse_count == '0) begin
            dir_forward_next = 1'b1;
            duty_level_next  = '0;
            finished_next    = 1'b1;
            home_run_next    = 1'b0;
          end
        end
      end
      OP_CLEAR: pulse_count_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count  <= '0;
      goal_count   <= IDLE_GOAL;
      finished     <= 1'b0;
      dir_forward  <= 1'b0;
      duty_level   <= '0;
      home_run     <= 1'b0;
      status_valid <= 1'b0;
    end else begin
      if (work_pop) begin
        pulse_count <= pulse_count_next;
        goal_count  <= goal_count_next;
        finished    <= finished_next;
        dir_forward <= dir_forward_next;
        duty_level  <= duty_level_next;
        home_run    <= home_run_next;
      end
      if (work_pop) begin
        status_valid <= 1'b1;
      end else if (!status_stall) begin
        status_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work_pop) begin
      status.position      <= $signed(16'(pulse_count_next));
      status.move_done     <= finished_next;
      status.drive_forward <= dir_forward_next;
      status.duty          <= duty_level_next;
      status.homing_active <= home_run_next;
    end
  end

endmodule

@@ rtl/encoder_target_positioner.sv @@
// ----------------------------------------------------------------------------
// encoder_target_positioner
// Actuator positioner: encoder pulse count, move targets, homing, drive.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one transaction per encoder
//   pulse, move command, homing start, homing tick or count clear.
//   status channel (status_valid / status_stall / status): exactly one
//   transaction per command, carrying the count and drive state after it.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
//   stroke_pulses (index 0, low 15 bits) or pulse_limit (index 1); cfg_ready
//   is always high. Write only while no command is in flight.
// Timing:
//   A command passes through three front stages (decode and mm *
//   stroke_pulses, reciprocal divide by 150, fixup), one queue write, and
//   the back stage that updates the state and registers the status. One
//   command per cycle sustained while status_stall stays low.
// Stall:
//   A stalled status holds; the two-entry work queue keeps absorbing, then
//   the front pipeline freezes and cmd_stall rises.
// Reset (rst, synchronous): count 0, goal at the idle mark, motor reverse at
//   duty 0, not done, not homing; stroke_pulses 1000, pulse_limit 32767.
// ----------------------------------------------------------------------------
module encoder_target_positioner (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  etp_pkg::cmd_t      cmd,
  output logic               status_valid,
  input  logic               status_stall,
  output etp_pkg::status_t   status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import etp_pkg::*;

  // configuration registers
  logic [14:0]        stroke_pulses;
  logic signed [15:0] pulse_limit;

  work_t front_work;
  work_t queue_work;
  logic  work_push;
  logic  queue_full;
  logic  queue_empty;
  logic  work_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stroke_pulses <= STROKE_PULSES_RST;
      pulse_limit   <= PULSE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STROKE_PULSES: stroke_pulses <= cfg_data[14:0];
        REG_PULSE_LIMIT:   pulse_limit   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // front: accept, classify, scale absolute targets
  etp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .stroke_pulses (stroke_pulses),
    .work          (front_work),
    .work_push     (work_push),
    .work_full     (queue_full)
  );

  etp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (work_push),
    .full    (queue_full),
    .wr_data (front_work),
    .pop     (work_pop),
    .ready_n (queue_empty),
    .rd_data (queue_work)
  );

  // back: state update and status register
  etp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .work_empty   (queue_empty),
    .work         (queue_work),
    .work_pop     (work_pop),
    .pulse_limit  (pulse_limit),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status)
  );

endmodule
